[hw/rtl/mhpq_pkg.sv]
package mhpq_pkg;

    localparam int DEF_CAPACITY = 2048;
    localparam int KEY_W        = 32;
    localparam int POS_W        = 12;
    localparam int TOTAL_W      = 12;
    localparam int LEVEL_W      = 4;

    localparam logic [1:0] KIND_INSERT  = 2'd0;
    localparam logic [1:0] KIND_DEL_MAX = 2'd1;
    localparam logic [1:0] KIND_DEL_POS = 2'd2;
    localparam logic [1:0] KIND_DEL_MIN = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_BAD   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_RDL,
        ST_DN_RDR,
        ST_DN_CMP,
        ST_MIN_SCAN,
        ST_MIN_LAST,
        ST_RD_HOLE,
        ST_RD_LAST,
        ST_GOT_LAST,
        ST_DONE
    } state_t;

    // floor(log2(n + 1)), masked to the level field width
    function automatic logic [LEVEL_W-1:0] level_of(input logic [31:0] n);
        logic [32:0] v;
        logic [5:0]  lv;
        v  = {1'b0, n} + 33'd1;
        lv = 6'd0;
        for (int b = 1; b < 33; b++)
        begin
            if (v[b])
            begin
                lv = 6'(b);
            end
        end
        return lv[LEVEL_W-1:0];
    endfunction

endpackage

[hw/rtl/max_heap_priority_queue_top.sv]
// Binary max-heap priority queue of signed 32-bit keys in a single-port-write,
// registered-read memory. Raise start with kind, key_value and position while
// busy is low; busy then stays high until the request finishes, and the result
// appears on removed_value, status, entry_total and level_total for exactly one
// cycle with done high. Results cannot be held off: capture them when done is
// high. Steps: an error request goes straight to done; removing the last slot
// only drops the count; insert climbs from the new slot one level per parent
// compare and stops at the root or below a parent that is not smaller;
// remove-maximum moves the last key to slot 1 and sinks it, reading both
// children per level; remove-at-position does the same from slot 1, else the
// moved key climbs or, if it cannot, sinks; remove-minimum scans every leaf
// one per cycle (count - count/2 leaves), then moves the last key into the
// smallest leaf's slot and climbs it, unless that leaf is the last slot. The
// memory gives one read per cycle. No clearing pass is needed: only slots
// below the count are read.
module max_heap_priority_queue_top #(
    parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      kind,
    input  logic signed [mhpq_pkg::KEY_W-1:0] key_value,
    input  logic [mhpq_pkg::POS_W-1:0]      position,
    output logic                            done,
    output logic signed [mhpq_pkg::KEY_W-1:0] removed_value,
    output logic [1:0]                      status,
    output logic [mhpq_pkg::TOTAL_W-1:0]    entry_total,
    output logic [mhpq_pkg::LEVEL_W-1:0]    level_total
);
    import mhpq_pkg::*;

    localparam int IW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int PCW = (CW > POS_W) ? CW : POS_W;
    localparam int LW  = IW + 2;

    // key store
    logic signed [KEY_W-1:0] mem [CAPACITY];
    logic signed [KEY_W-1:0] rd_data_reg;
    logic [IW-1:0]           rd_addr;
    logic                    we;
    logic [IW-1:0]           wa;
    logic signed [KEY_W-1:0] wd;

    state_t state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [1:0]              kind_reg, kind_next;
    logic [IW-1:0]           hole_reg, hole_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic signed [KEY_W-1:0] left_reg, left_next;
    logic signed [KEY_W-1:0] removed_reg, removed_next;
    logic [1:0]              status_reg, status_next;
    logic                    first_reg, first_next;
    logic [CW-1:0]           scan_reg, scan_next;
    logic [IW-1:0]           cmp_idx_reg, cmp_idx_next;
    logic [IW-1:0]           best_idx_reg, best_idx_next;
    logic signed [KEY_W-1:0] best_val_reg, best_val_next;
    logic                    best_ok_reg, best_ok_next;

    // derived indexes
    logic [LW-1:0]  left_idx;
    logic [LW-1:0]  right_idx;
    logic [LW-1:0]  count_ext;
    logic [IW-1:0]  parent_idx;
    logic [IW-1:0]  last_idx;
    logic [PCW-1:0] pos_ext;
    logic [PCW-1:0] cnt_pos;
    logic           right_ok;
    logic           take_right;
    logic signed [KEY_W-1:0] child_val;
    logic [IW-1:0]  child_idx;
    logic           min_take;
    logic [IW-1:0]  min_idx;
    logic signed [KEY_W-1:0] min_val;
    logic           accept;

    assign accept     = start && (state_reg == ST_IDLE);
    assign left_idx   = {1'b0, hole_reg, 1'b1};
    assign right_idx  = left_idx + LW'(1);
    assign count_ext  = LW'(count_reg);
    assign parent_idx = IW'((hole_reg - IW'(1)) >> 1);
    assign last_idx   = IW'(count_reg - CW'(1));
    assign pos_ext    = PCW'(position);
    assign cnt_pos    = PCW'(count_reg);
    assign right_ok   = right_idx < count_ext;
    assign take_right = right_ok && (rd_data_reg > left_reg);
    assign child_val  = take_right ? rd_data_reg : left_reg;
    assign child_idx  = take_right ? right_idx[IW-1:0] : left_idx[IW-1:0];
    // lowest index wins ties: replace only on a strictly smaller key
    assign min_take   = !best_ok_reg || (best_val_reg > rd_data_reg);
    assign min_idx    = min_take ? cmp_idx_reg : best_idx_reg;
    assign min_val    = min_take ? rd_data_reg : best_val_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (kind == KIND_INSERT)
                    begin
                        state_next = (count_reg >= CW'(CAPACITY)) ? ST_DONE : ST_UP_RD;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (kind == KIND_DEL_MAX)
                    begin
                        state_next = ST_RD_HOLE;
                    end
                    else if (kind == KIND_DEL_POS)
                    begin
                        if (pos_ext == '0 || pos_ext > cnt_pos)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_RD_HOLE;
                        end
                    end
                    else
                    begin
                        state_next = ST_MIN_SCAN;
                    end
                end
            end
            ST_RD_HOLE:  state_next = ST_RD_LAST;
            ST_RD_LAST:  state_next = ST_GOT_LAST;
            ST_GOT_LAST:
            begin
                if (hole_reg == IW'(count_reg) && count_reg != CW'(CAPACITY))
                begin
                    state_next = ST_DONE;
                end
                else if (kind_reg == KIND_DEL_MAX)
                begin
                    state_next = ST_DN_RDL;
                end
                else if (kind_reg == KIND_DEL_POS && hole_reg == '0)
                begin
                    state_next = ST_DN_RDL;
                end
                else
                begin
                    state_next = ST_UP_RD;
                end
            end
            ST_UP_RD:    state_next = (hole_reg == '0) ? ST_DONE : ST_UP_CMP;
            ST_UP_CMP:
            begin
                if (key_reg > rd_data_reg)
                begin
                    state_next = ST_UP_RD;
                end
                else
                begin
                    state_next = first_reg ? ST_DN_RDL : ST_DONE;
                end
            end
            ST_DN_RDL:   state_next = (left_idx >= count_ext) ? ST_DONE : ST_DN_RDR;
            ST_DN_RDR:   state_next = ST_DN_CMP;
            ST_DN_CMP:   state_next = (child_val > key_reg) ? ST_DN_RDL : ST_DONE;
            ST_MIN_SCAN:
            begin
                if (scan_reg == CW'(last_idx))
                begin
                    state_next = ST_MIN_LAST;
                end
            end
            ST_MIN_LAST: state_next = ST_RD_LAST;
            ST_DONE:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        count_next    = count_reg;
        kind_next     = kind_reg;
        hole_next     = hole_reg;
        key_next      = key_reg;
        left_next     = left_reg;
        removed_next  = removed_reg;
        status_next   = status_reg;
        first_next    = first_reg;
        scan_next     = scan_reg;
        cmp_idx_next  = cmp_idx_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        best_ok_next  = best_ok_reg;
        rd_addr       = hole_reg;
        we            = 1'b0;
        wa            = hole_reg;
        wd            = key_reg;
        case (state_reg)
            ST_IDLE:
            begin
                kind_next    = kind;
                removed_next = '0;
                status_next  = STAT_OK;
                first_next   = 1'b0;
                best_ok_next = 1'b0;
                scan_next    = count_reg >> 1;
                key_next     = key_value;
                // hold the count until a request is actually taken
                if (start)
                begin
                    if (kind == KIND_INSERT)
                    begin
                        if (count_reg >= CW'(CAPACITY))
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            hole_next  = IW'(count_reg);
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else if (kind == KIND_DEL_MAX)
                    begin
                        hole_next = '0;
                    end
                    else if (kind == KIND_DEL_POS)
                    begin
                        if (pos_ext == '0 || pos_ext > cnt_pos)
                        begin
                            status_next = STAT_BAD;
                        end
                        else
                        begin
                            hole_next  = IW'(pos_ext - PCW'(1));
                            first_next = 1'b1;
                        end
                    end
                end
            end
            ST_RD_HOLE:
            begin
                rd_addr = hole_reg;
            end
            ST_RD_LAST:
            begin
                rd_addr = last_idx;
                if (kind_reg != KIND_DEL_MIN)
                begin
                    removed_next = rd_data_reg;
                end
                count_next = count_reg - CW'(1);
            end
            ST_GOT_LAST:
            begin
                key_next = rd_data_reg;
            end
            ST_UP_RD:
            begin
                rd_addr = parent_idx;
                if (hole_reg == '0)
                begin
                    we = 1'b1;
                end
            end
            ST_UP_CMP:
            begin
                if (key_reg > rd_data_reg)
                begin
                    we         = 1'b1;
                    wd         = rd_data_reg;
                    hole_next  = parent_idx;
                    first_next = 1'b0;
                end
                else if (!first_reg)
                begin
                    we = 1'b1;
                end
            end
            ST_DN_RDL:
            begin
                rd_addr = left_idx[IW-1:0];
                if (left_idx >= count_ext)
                begin
                    we = 1'b1;
                end
            end
            ST_DN_RDR:
            begin
                left_next = rd_data_reg;
                rd_addr   = right_idx[IW-1:0];
            end
            ST_DN_CMP:
            begin
                we = 1'b1;
                if (child_val > key_reg)
                begin
                    wd        = child_val;
                    hole_next = child_idx;
                end
            end
            ST_MIN_SCAN:
            begin
                rd_addr = IW'(scan_reg);
                if (first_reg)
                begin
                    best_idx_next = min_idx;
                    best_val_next = min_val;
                    best_ok_next  = 1'b1;
                end
                first_next   = 1'b1;
                cmp_idx_next = IW'(scan_reg);
                scan_next    = scan_reg + CW'(1);
            end
            ST_MIN_LAST:
            begin
                hole_next    = min_idx;
                removed_next = min_val;
                first_next   = 1'b0;
            end
            default:
            begin
                rd_addr = hole_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        hole_reg     <= hole_next;
        key_reg      <= key_next;
        left_reg     <= left_next;
        removed_reg  <= removed_next;
        status_reg   <= status_next;
        first_reg    <= first_next;
        scan_reg     <= scan_next;
        cmp_idx_reg  <= cmp_idx_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        best_ok_reg  <= best_ok_next;
    end

    // outputs
    always_comb
    begin
        busy          = (state_reg != ST_IDLE);
        done          = (state_reg == ST_DONE);
        removed_value = removed_reg;
        status        = status_reg;
        entry_total   = TOTAL_W'(count_reg);
        level_total   = level_of(32'(count_reg));
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("done not followed by idle");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted request did not raise busy");

    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (CW'(wa) < count_reg))
        else $error("write outside held entries");

endmodule

[sim/max_heap_priority_queue_top_tb.sv]
`timescale 1ns / 1ps

module max_heap_priority_queue_top_tb;
    import mhpq_pkg::*;

    localparam int CAP = DEF_CAPACITY;

    typedef struct packed {
        logic signed [KEY_W-1:0] removed_value;
        logic [1:0]              status;
        logic [TOTAL_W-1:0]      entry_total;
        logic [LEVEL_W-1:0]      level_total;
    } heap_reply_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [1:0]                kind;
    logic signed [KEY_W-1:0]   key_value;
    logic [POS_W-1:0]          position;
    logic                      done;
    logic signed [KEY_W-1:0]   removed_value;
    logic [1:0]                status;
    logic [TOTAL_W-1:0]        entry_total;
    logic [LEVEL_W-1:0]        level_total;

    max_heap_priority_queue_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .key_value     (key_value),
        .position      (position),
        .done          (done),
        .removed_value (removed_value),
        .status        (status),
        .entry_total   (entry_total),
        .level_total   (level_total)
    );

    // Shadow copy of the heap kept by the predictor
    logic signed [KEY_W-1:0] shadow_keys [CAP];
    int unsigned             shadow_count;
    heap_reply_t             pending_replies [$];
    int                      error_count;
    int                      word_count;
    int                      reply_count;
    int unsigned             peak_count;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic void swap_keys(input int unsigned a, input int unsigned b);
        logic signed [KEY_W-1:0] t;
        t              = shadow_keys[a];
        shadow_keys[a] = shadow_keys[b];
        shadow_keys[b] = t;
    endfunction

    function automatic void climb(input int unsigned slot);
        int unsigned i;
        int unsigned p;
        i = slot;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (shadow_keys[i] <= shadow_keys[p])
                break;
            swap_keys(i, p);
            i = p;
        end
    endfunction

    // Follow the larger child down while it beats the parent
    function automatic void descend(input int unsigned slot);
        int unsigned i;
        int unsigned l;
        int unsigned c;
        i = slot;
        forever
        begin
            l = 2 * i + 1;
            if (l >= shadow_count)
                break;
            c = l;
            if (l + 1 < shadow_count && shadow_keys[l + 1] > shadow_keys[l])
                c = l + 1;
            if (shadow_keys[c] <= shadow_keys[i])
                break;
            swap_keys(c, i);
            i = c;
        end
    endfunction

    // Apply one request to the shadow heap and build the reply it should give
    function automatic heap_reply_t heap_apply(input logic [1:0] k,
                                               input logic signed [KEY_W-1:0] key,
                                               input logic [POS_W-1:0] pos);
        heap_reply_t r;
        int unsigned h;
        int unsigned best;
        int unsigned lv;
        int unsigned v;
        r = '0;
        if (k == KIND_INSERT)
        begin
            if (shadow_count >= CAP)
                r.status = STAT_FULL;
            else
            begin
                shadow_keys[shadow_count] = key;
                shadow_count++;
                climb(shadow_count - 1);
            end
        end
        else if (shadow_count == 0)
            r.status = STAT_EMPTY;
        else if (k == KIND_DEL_MAX)
        begin
            r.removed_value = shadow_keys[0];
            shadow_count--;
            shadow_keys[0] = shadow_keys[shadow_count];
            descend(0);
        end
        else if (k == KIND_DEL_POS)
        begin
            if (pos < 1 || pos > shadow_count)
                r.status = STAT_BAD;
            else
            begin
                h = pos - 1;
                r.removed_value = shadow_keys[h];
                shadow_count--;
                if (h != shadow_count)
                begin
                    shadow_keys[h] = shadow_keys[shadow_count];
                    if (h > 0 && shadow_keys[h] > shadow_keys[(h - 1) / 2])
                        climb(h);
                    else
                        descend(h);
                end
            end
        end
        else
        begin
            // smallest leaf, lowest slot on ties
            best = shadow_count / 2;
            for (int unsigned j = best + 1; j < shadow_count; j++)
                if (shadow_keys[best] > shadow_keys[j])
                    best = j;
            r.removed_value = shadow_keys[best];
            shadow_count--;
            if (best != shadow_count)
            begin
                shadow_keys[best] = shadow_keys[shadow_count];
                climb(best);
            end
        end
        lv = 0;
        v  = shadow_count + 1;
        while (v > 1)
        begin
            v >>= 1;
            lv++;
        end
        r.entry_total = shadow_count[TOTAL_W-1:0];
        r.level_total = lv[LEVEL_W-1:0];
        return r;
    endfunction

    // Send one word: idle for a random gap, then hold start until accepted.
    // Start is only lowered for a gap so it never drops and rises in one step.
    task automatic send_word(input logic [1:0] k,
                             input logic signed [KEY_W-1:0] key,
                             input logic [POS_W-1:0] pos);
        int unsigned gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        kind      <= k;
        key_value <= key;
        position  <= pos;
        // busy read here is the value before this edge
        do
            @(posedge clk);
        while (busy);
        pending_replies.push_back(heap_apply(k, key, pos));
        word_count++;
        if (shadow_count > peak_count)
            peak_count = shadow_count;
    endtask

    task automatic send_insert(input logic signed [KEY_W-1:0] key);
        send_word(KIND_INSERT, key, POS_W'($urandom));
    endtask

    task automatic send_removal(input logic [1:0] k, input logic [POS_W-1:0] pos);
        send_word(k, KEY_W'($urandom), pos);
    endtask

    // Check every reply against the oldest expectation
    always @(posedge clk)
    begin
        heap_reply_t e;
        if (rst_n && done)
        begin
            reply_count++;
            if (pending_replies.size() == 0)
            begin
                $error("unexpected reply: removed_value %0d status %0d",
                       removed_value, status);
                error_count++;
            end
            else
            begin
                e = pending_replies.pop_front();
                if (removed_value !== e.removed_value)
                begin
                    $error("removed_value: expected %0d, got %0d",
                           e.removed_value, removed_value);
                    error_count++;
                end
                if (status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, status);
                    error_count++;
                end
                if (entry_total !== e.entry_total)
                begin
                    $error("entry_total: expected %0d, got %0d",
                           e.entry_total, entry_total);
                    error_count++;
                end
                if (level_total !== e.level_total)
                begin
                    $error("level_total: expected %0d, got %0d",
                           e.level_total, level_total);
                    error_count++;
                end
            end
        end
    end

    // Empty heap, extreme keys, ties, bad positions, every kind of removal
    task automatic test_directed();
        send_removal(KIND_DEL_MAX, 12'd1);
        send_removal(KIND_DEL_POS, 12'd1);
        send_removal(KIND_DEL_MIN, 12'd0);
        send_insert(32'sh7FFF_FFFF);
        send_insert(-32'sh8000_0000);
        send_insert(32'sd0);
        send_insert(-32'sd1);
        send_insert(32'sd5);
        send_insert(32'sd5);
        send_insert(-32'sd1);
        send_removal(KIND_DEL_POS, 12'd0);
        send_removal(KIND_DEL_POS, 12'd8);
        send_removal(KIND_DEL_POS, 12'hFFF);
        send_removal(KIND_DEL_POS, 12'd7);         // last slot: count just drops
        send_removal(KIND_DEL_MIN, 12'd0);
        send_insert(-32'sd1);
        send_removal(KIND_DEL_MIN, 12'd0);         // tie among leaves
        send_insert(32'sd3);
        send_insert(32'sd100);
        send_removal(KIND_DEL_POS, 12'd2);         // moved entry may climb
        send_removal(KIND_DEL_POS, 12'd1);
        send_removal(KIND_DEL_MAX, 12'd0);
        while (shadow_count > 0)
            send_removal(KIND_DEL_MAX, 12'd0);
        send_removal(KIND_DEL_MIN, 12'd0);
    endtask

    function automatic logic signed [KEY_W-1:0] draw_key();
        case ($urandom_range(0, 3))
            0: return KEY_W'($signed($urandom_range(0, 8)) - 4);
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : -32'sh8000_0000;
            default: return KEY_W'($urandom);
        endcase
    endfunction

    // Mostly well-formed traffic on a heap that drifts between empty and ~60
    task automatic test_random(input int items);
        int unsigned target;
        int unsigned sel;
        logic [POS_W-1:0] pos;
        target = 20;
        repeat (items)
        begin
            if ($urandom_range(0, 40) == 0)
                target = $urandom_range(0, 60);
            sel = $urandom_range(0, 99);
            if (sel < 10)
            begin
                // noise: any kind, any position bits
                send_word(2'($urandom), draw_key(), POS_W'($urandom));
            end
            else if (shadow_count < target ? sel < 70 : sel < 35)
                send_insert(draw_key());
            else
            begin
                case ($urandom_range(0, 2))
                    0: send_removal(KIND_DEL_MAX, POS_W'($urandom));
                    1: send_removal(KIND_DEL_MIN, POS_W'($urandom));
                    default:
                    begin
                        pos = (shadow_count > 0 && $urandom_range(0, 9) != 0) ?
                              POS_W'($urandom_range(1, shadow_count)) :
                              POS_W'($urandom_range(0, shadow_count + 2));
                        send_removal(KIND_DEL_POS, pos);
                    end
                endcase
            end
        end
    endtask

    initial
    begin
        int wait_cycles;
        error_count  = 0;
        word_count   = 0;
        reply_count  = 0;
        peak_count   = 0;
        shadow_count = 0;
        rst_n     = 1'b0;
        start     = 1'b0;
        kind      = KIND_INSERT;
        key_value = '0;
        position  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(620);

        start <= 1'b0;
        wait_cycles = 0;
        while (pending_replies.size() > 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (40) @(posedge clk);
        if (pending_replies.size() > 0)
        begin
            $error("%0d replies never arrived", pending_replies.size());
            error_count++;
        end

        $display("Sent %0d requests, checked %0d replies, heap peaked at %0d keys.",
                 word_count, reply_count, peak_count);
        $display("Covered all four kinds, the empty heap and bad positions.");
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
